/* hdl/ufd_pkg.sv */
// ----------------------------------------------------------------------------
// ufd_pkg
// Shared constants, controller commands and status for the form decoder.
// ----------------------------------------------------------------------------
package ufd_pkg;

  localparam int unsigned PENDING_DEPTH_DFLT = 32;

  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_HOLD,
    CMD_SHIFT_OVF,
    CMD_FLUSH,
    CMD_EMIT,
    CMD_FINISH
  } ufd_cmd_e;

  typedef struct packed {
    logic cand_done;
    logic cand_nl;
    logic any;
    logic full;
    logic pend_zero;
    logic adv;
  } ufd_status_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    hex_val = v[3:0];
  endfunction

endpackage

/* hdl/ufd_ctrl.sv */
// ----------------------------------------------------------------------------
// ufd_ctrl
// Sequencer: loads a byte, walks its decoded candidates one result per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module ufd_ctrl
  import ufd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ufd_status_t status_i,
  output ufd_cmd_e    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CAND,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_CAND;
        end
      end
      S_CAND: begin
        if (status_i.cand_done) begin
          state_d = S_FINISH;
        end else if (status_i.cand_nl && status_i.any) begin
          // newline after the first byte: hold it; store full: push out the oldest held newline, flagged
          if (!status_i.full) cmd_o = CMD_HOLD;
          else if (status_i.adv) cmd_o = CMD_SHIFT_OVF;
        end else if (status_i.adv) begin
          cmd_o = status_i.pend_zero ? CMD_EMIT : CMD_FLUSH;
        end
      end
      S_FINISH: begin
        if (status_i.adv) begin
          cmd_o   = CMD_FINISH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_load_to_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q == S_CAND))
    else $error("load did not start candidate walk");

  a_finish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o == CMD_FINISH) |=> (state_q == S_IDLE))
    else $error("finish did not return to idle");

  a_finish_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && !status_i.adv) |=> (state_q == S_FINISH))
    else $error("finish left while output blocked");

endmodule

/* hdl/ufd_datapath.sv */
// ----------------------------------------------------------------------------
// ufd_datapath
// Escape decode, candidate list, held newline store and output registers.
// ----------------------------------------------------------------------------
module ufd_datapath
  import ufd_pkg::*;
#(
  parameter int unsigned PENDING_DEPTH = PENDING_DEPTH_DFLT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ufd_cmd_e    cmd_i,
  output ufd_status_t status_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic        out_empty_o,
  output logic        out_overflow_o
);

  localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam logic [CW-1:0] FULL = CW'(PENDING_DEPTH);

  typedef enum logic [1:0] {
    PH_NONE,
    PH_PCT,
    PH_DIG
  } phase_e;

  phase_e      phase_q, ld_phase;
  logic [7:0]  held_q, ld_held;
  logic [7:0]  cand_q [3];
  logic [7:0]  ld_cand [3];
  logic [1:0]  ncand_q, ld_n;
  logic [1:0]  idx_q;
  logic        last_q;
  logic [CW-1:0] count_q;
  logic        any_q;
  logic        kind_q [PENDING_DEPTH];
  logic        hr_valid_q;
  logic [7:0]  hr_byte_q;
  logic        hr_ovf_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q, out_empty_q, out_ovf_q;

  logic        tp_valid, tp_pct, b_hex;
  logic [7:0]  tp_byte;
  logic        cand_done, adv;
  logic [7:0]  cur;
  logic        cur_cr;
  logic        new_res, new_ovf;
  logic [7:0]  new_byte;
  logic        out_wr;
  logic [7:0]  out_byte_d;
  logic        out_last_d, out_empty_d, out_ovf_d;

  // plain handling of the incoming byte
  assign b_hex    = is_hex(in_byte_i);
  assign tp_pct   = (in_byte_i == CH_PCT);
  assign tp_valid = !tp_pct && (in_byte_i != CH_CR);
  assign tp_byte  = (in_byte_i == CH_PLUS) ? CH_SPACE : in_byte_i;

  always_comb begin
    ld_cand  = '{default: 8'h00};
    ld_n     = 2'd0;
    ld_phase = phase_q;
    ld_held  = held_q;
    case (phase_q)
      PH_NONE: begin
        ld_phase = tp_pct ? PH_PCT : PH_NONE;
        if (tp_valid) begin
          ld_cand[ld_n] = tp_byte;
          ld_n = ld_n + 2'd1;
        end
      end
      PH_PCT: begin
        if (b_hex) begin
          ld_held  = in_byte_i;
          ld_phase = PH_DIG;
        end else begin
          ld_cand[ld_n] = CH_PCT;
          ld_n = ld_n + 2'd1;
          ld_phase = tp_pct ? PH_PCT : PH_NONE;
          if (tp_valid) begin
            ld_cand[ld_n] = tp_byte;
            ld_n = ld_n + 2'd1;
          end
        end
      end
      PH_DIG: begin
        if (b_hex) begin
          ld_cand[ld_n] = {hex_val(held_q), hex_val(in_byte_i)};
          ld_n = ld_n + 2'd1;
          ld_phase = PH_NONE;
        end else begin
          ld_cand[ld_n] = CH_PCT;
          ld_n = ld_n + 2'd1;
          ld_cand[ld_n] = held_q;
          ld_n = ld_n + 2'd1;
          ld_phase = tp_pct ? PH_PCT : PH_NONE;
          if (tp_valid) begin
            ld_cand[ld_n] = tp_byte;
            ld_n = ld_n + 2'd1;
          end
        end
      end
      default: ld_phase = PH_NONE;
    endcase
    // an escape cut by the end of the string goes out literally
    if (in_last_i) begin
      if (ld_phase == PH_PCT) begin
        ld_cand[ld_n] = CH_PCT;
        ld_n = ld_n + 2'd1;
      end else if (ld_phase == PH_DIG) begin
        ld_cand[ld_n] = CH_PCT;
        ld_n = ld_n + 2'd1;
        ld_cand[ld_n] = ld_held;
        ld_n = ld_n + 2'd1;
      end
      ld_phase = PH_NONE;
      ld_held  = 8'h00;
    end
  end

  assign cand_done = (idx_q == ncand_q);
  assign cur       = cand_done ? 8'h00 : cand_q[idx_q];
  assign cur_cr    = (cur == CH_CR);
  assign adv       = !out_valid_q || !out_stall_i;

  assign status_o.cand_done = cand_done;
  assign status_o.cand_nl   = (cur == CH_LF) || cur_cr;
  assign status_o.any       = any_q;
  assign status_o.full      = (count_q == FULL);
  assign status_o.pend_zero = (count_q == '0);
  assign status_o.adv       = adv;

  always_comb begin
    new_res  = 1'b0;
    new_ovf  = 1'b0;
    new_byte = cur;
    case (cmd_i)
      CMD_SHIFT_OVF: begin
        new_res  = 1'b1;
        new_ovf  = 1'b1;
        new_byte = kind_q[0] ? CH_CR : CH_LF;
      end
      CMD_FLUSH: begin
        new_res  = 1'b1;
        new_byte = kind_q[0] ? CH_CR : CH_LF;
      end
      CMD_EMIT: new_res = 1'b1;
      default: new_res = 1'b0;
    endcase
  end

  // one result waits in hr so the final one of a string can carry last
  always_comb begin
    out_wr      = 1'b0;
    out_byte_d  = hr_byte_q;
    out_last_d  = 1'b0;
    out_empty_d = 1'b0;
    out_ovf_d   = hr_ovf_q;
    if (cmd_i == CMD_FINISH) begin
      out_wr      = hr_valid_q || last_q;
      out_byte_d  = hr_valid_q ? hr_byte_q : 8'h00;
      out_last_d  = last_q;
      out_empty_d = !hr_valid_q;
      out_ovf_d   = hr_valid_q && hr_ovf_q;
    end else if (new_res) begin
      out_wr = hr_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_NONE;
      ncand_q     <= 2'd0;
      idx_q       <= 2'd0;
      count_q     <= '0;
      any_q       <= 1'b0;
      hr_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i)
        CMD_LOAD: begin
          phase_q <= ld_phase;
          ncand_q <= ld_n;
          idx_q   <= 2'd0;
        end
        CMD_HOLD: begin
          count_q <= count_q + CW'(1);
          idx_q   <= idx_q + 2'd1;
        end
        CMD_SHIFT_OVF: idx_q <= idx_q + 2'd1;
        CMD_FLUSH: count_q <= count_q - CW'(1);
        CMD_EMIT: begin
          any_q <= 1'b1;
          idx_q <= idx_q + 2'd1;
        end
        CMD_FINISH: begin
          if (last_q) begin
            count_q <= '0;
            any_q   <= 1'b0;
          end
        end
        default: idx_q <= idx_q;
      endcase
      if (cmd_i == CMD_FINISH) hr_valid_q <= 1'b0;
      else if (new_res) hr_valid_q <= 1'b1;
      out_valid_q <= out_wr || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD) begin
      held_q <= ld_held;
      cand_q <= ld_cand;
      last_q <= in_last_i;
    end
    if (new_res) begin
      hr_byte_q <= new_byte;
      hr_ovf_q  <= new_ovf;
    end
    if (out_wr) begin
      out_byte_q  <= out_byte_d;
      out_last_q  <= out_last_d;
      out_empty_q <= out_empty_d;
      out_ovf_q   <= out_ovf_d;
    end
    // drop the oldest held newline, append at the tail
    if (cmd_i == CMD_SHIFT_OVF || cmd_i == CMD_FLUSH) begin
      for (int i = 0; i < int'(PENDING_DEPTH) - 1; i++) begin
        kind_q[i] <= kind_q[i+1];
      end
    end
    if (cmd_i == CMD_SHIFT_OVF) begin
      kind_q[PENDING_DEPTH-1] <= cur_cr;
    end else if (cmd_i == CMD_HOLD) begin
      kind_q[count_q[IW-1:0]] <= cur_cr;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign out_last_o     = out_last_q;
  assign out_empty_o    = out_empty_q;
  assign out_overflow_o = out_ovf_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL)
    else $error("held newline count beyond store depth");

  a_hold_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_HOLD) |-> (any_q && count_q != FULL))
    else $error("newline held with full store or before first byte");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_wr)
    else $error("output register overwritten while stalled");

endmodule

/* hdl/url_form_decoder.sv */
// ----------------------------------------------------------------------------
// url_form_decoder
// Streaming form-urlencoded decoder with trailing newline trim.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Beat payload
//  in       input      in_valid_i/in_stall_o   in_byte_i, in_last_i
//  out      output     out_valid_o/out_stall_i out_byte_o, out_last_o,
//                                              out_empty_o, out_overflow_o
//
//  Per beat: load, then one step per decoded candidate byte (0..3) and per
//  held newline flushed ahead of a data byte, then finish; a newline forced
//  out of a full store takes its own candidate's step. No new beat until finish.
//  Reset clears all control state at once; no clearing pass.
//  An output stall pauses the sequencer; the next input beat is taken
//  while the last result still waits in the output register.
// ----------------------------------------------------------------------------
module url_form_decoder
  import ufd_pkg::*;
#(
  parameter int unsigned PENDING_DEPTH = PENDING_DEPTH_DFLT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       out_empty_o,
  output logic       out_overflow_o
);

  ufd_cmd_e    cmd;
  ufd_status_t status;

  ufd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ufd_datapath #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .in_byte_i      (in_byte_i),
    .in_last_i      (in_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .out_last_o     (out_last_o),
    .out_empty_o    (out_empty_o),
    .out_overflow_o (out_overflow_o)
  );

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives encoded form strings into url_form_decoder with random gaps and
// output stalls, predicts every decoded beat in-line and checks each output
// beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import ufd_pkg::*;

  localparam int NL_DEPTH     = PENDING_DEPTH_DFLT;
  localparam int IDLE_LIMIT   = 4000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int RAND_ITEMS   = 400;

  typedef enum logic [1:0] {ESC_IDLE, ESC_PCT, ESC_DIGIT} esc_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } enc_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
    logic       ovf;
  } dec_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_last_o;
  logic       out_empty_o;
  logic       out_overflow_o;

  url_form_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .in_last_i     (in_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .out_last_o    (out_last_o),
    .out_empty_o   (out_empty_o),
    .out_overflow_o(out_overflow_o)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state
  esc_e       esc_phase = ESC_IDLE;
  logic [7:0] held_digit = 8'h00;
  bit         held_nl [NL_DEPTH];
  int         held_nl_cnt = 0;
  bit         any_out = 1'b0;

  enc_beat_t  raw_q[$];
  dec_beat_t  step_q[$];
  dec_beat_t  decoded_q[$];
  logic [7:0] str_q[$];

  int err_cnt = 0;
  int rand_items = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int send_gap = 0;
  int send_calm = 0;
  int stall_left = 0;
  int stall_calm = 0;
  int idle_cycles = 0;
  enc_beat_t nxt;

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic bit hex_digit_ok(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
    return 4'h0;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic put_out(input logic [7:0] b, input logic ovf);
    step_q.push_back({b, 1'b0, 1'b0, ovf});
  endtask

  task automatic emit_byte(input logic [7:0] b);
    int i;
    if (b == CH_LF || b == CH_CR) begin
      if (!any_out) begin
        put_out(b, 1'b0);
        any_out = 1'b1;
      end else begin
        // Full store: force out the oldest held newline.
        if (held_nl_cnt >= NL_DEPTH) begin
          put_out(held_nl[0] ? CH_CR : CH_LF, 1'b1);
          for (i = 1; i < NL_DEPTH; i++) held_nl[i-1] = held_nl[i];
          held_nl_cnt = NL_DEPTH - 1;
        end
        held_nl[held_nl_cnt] = (b == CH_CR);
        held_nl_cnt++;
      end
    end else begin
      for (i = 0; i < held_nl_cnt; i++) put_out(held_nl[i] ? CH_CR : CH_LF, 1'b0);
      held_nl_cnt = 0;
      put_out(b, 1'b0);
      any_out = 1'b1;
    end
  endtask

  task automatic take_plain(input logic [7:0] b);
    if (b == CH_PLUS) emit_byte(CH_SPACE);
    else if (b == CH_PCT) esc_phase = ESC_PCT;
    else if (b != CH_CR) emit_byte(b);
  endtask

  task automatic decode_beat(input logic [7:0] b, input logic last);
    dec_beat_t tail;
    int i;
    case (esc_phase)
      ESC_PCT: begin
        if (hex_digit_ok(b)) begin
          held_digit = b;
          esc_phase = ESC_DIGIT;
        end else begin
          esc_phase = ESC_IDLE;
          emit_byte(CH_PCT);
          take_plain(b);
        end
      end
      ESC_DIGIT: begin
        esc_phase = ESC_IDLE;
        if (hex_digit_ok(b)) begin
          emit_byte({nibble_of(held_digit), nibble_of(b)});
        end else begin
          emit_byte(CH_PCT);
          emit_byte(held_digit);
          take_plain(b);
        end
      end
      default: take_plain(b);
    endcase
    if (last) begin
      // Flush an escape cut short by the end of the string.
      if (esc_phase == ESC_PCT) begin
        emit_byte(CH_PCT);
      end else if (esc_phase == ESC_DIGIT) begin
        emit_byte(CH_PCT);
        emit_byte(held_digit);
      end
      if (step_q.size() > 0) begin
        tail = step_q[step_q.size()-1];
        tail.last = 1'b1;
        step_q[step_q.size()-1] = tail;
      end else begin
        step_q.push_back({8'h00, 1'b1, 1'b1, 1'b0});
      end
      esc_phase = ESC_IDLE;
      held_digit = 8'h00;
      held_nl_cnt = 0;
      any_out = 1'b0;
    end
    for (i = 0; i < step_q.size(); i++) decoded_q.push_back(step_q[i]);
    step_q.delete();
  endtask

  task automatic check_out();
    dec_beat_t want;
    if (decoded_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected beat, byte %02h", out_byte_o));
    end else begin
      want = decoded_q.pop_front();
      if (!want.empty && out_byte_o !== want.data)
        flag_mismatch($sformatf("out_byte %02h, want %02h", out_byte_o, want.data));
      if (out_last_o !== want.last)
        flag_mismatch($sformatf("out_last %b, want %b", out_last_o, want.last));
      if (out_empty_o !== want.empty)
        flag_mismatch($sformatf("out_empty %b, want %b", out_empty_o, want.empty));
      if (out_overflow_o !== want.ovf)
        flag_mismatch($sformatf("out_overflow %b, want %b", out_overflow_o, want.ovf));
    end
  endtask

  // Driver: predict on each accepted beat, then offer the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) decode_beat(in_byte_i, in_last_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (raw_q.size() > 0) begin
          nxt = raw_q.pop_front();
          in_byte_i <= nxt.data;
          in_last_i <= nxt.last;
          in_valid_i <= 1'b1;
          send_gap = idle_len(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check accepted output beats and drive the stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_out();
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = idle_len(stall_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic logic [7:0] nib_char(input logic [3:0] v, input bit upper);
    if (v < 10) return 8'("0" + v);
    return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  task automatic add_byte(input logic [7:0] b);
    str_q.push_back(b);
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) str_q.push_back(s[i]);
  endtask

  task automatic add_escape(input logic [7:0] v, input bit upper);
    add_byte(CH_PCT);
    add_byte(nib_char(v[7:4], upper));
    add_byte(nib_char(v[3:0], upper));
  endtask

  // Queue the collected string, last flag on its final beat.
  task automatic close_string();
    int i;
    for (i = 0; i < str_q.size(); i++) raw_q.push_back({str_q[i], i == str_q.size() - 1});
    rand_items += str_q.size();
    str_q.delete();
  endtask

  task automatic gen_form_string();
    int n, t, j, k, run;
    logic [7:0] b;
    n = $urandom_range(1, 10);
    for (t = 0; t < n; t++) begin
      k = $urandom_range(0, 99);
      if (k < 35) begin
        b = 8'($urandom_range(0, 255));
        add_byte(b);
      end else if (k < 45) begin
        add_byte(CH_PLUS);
      end else if (k < 65) begin
        b = 8'($urandom_range(0, 255));
        add_escape(b, 1'($urandom_range(0, 1)));
      end else if (k < 75) begin
        add_byte(CH_PCT);
        if ($urandom_range(0, 1))
          add_byte(nib_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        b = 8'($urandom_range(0, 255));
        while (hex_digit_ok(b)) b = 8'($urandom_range(0, 255));
        add_byte(b);
      end else if (k < 85) begin
        add_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
      end else if (k < 97) begin
        add_escape($urandom_range(0, 1) ? CH_LF : CH_CR, 1'($urandom_range(0, 1)));
      end else begin
        // Newline run that can be long enough to spill out of the held store.
        add_byte(8'h61 + 8'($urandom_range(0, 25)));
        run = $urandom_range(28, 40);
        for (j = 0; j < run; j++) begin
          case ($urandom_range(0, 2))
            0: add_byte(CH_LF);
            1: add_escape(CH_LF, 1'($urandom_range(0, 1)));
            default: add_escape(CH_CR, 1'($urandom_range(0, 1)));
          endcase
        end
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      add_byte(CH_PCT);
      if ($urandom_range(0, 1))
        add_byte(nib_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
    end
    close_string();
  endtask

  task automatic wait_drained();
    while (raw_q.size() != 0 || in_valid_i || decoded_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int next_pause;
    int i;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Plus, valid escape, lone percent, percent and one digit at the end.
    add_text("a+%41");
    close_string();
    add_text("%");
    close_string();
    add_text("%4");
    close_string();
    // Broken escapes, zero byte and top byte value.
    add_text("%z%4g");
    add_byte(8'h00);
    add_byte(8'hff);
    close_string();
    // Raw carriage return only: string ends empty.
    add_byte(CH_CR);
    close_string();
    // Leading decoded newline kept, trailing decoded newlines trimmed.
    add_text("%0ax%0D");
    add_byte(CH_LF);
    close_string();
    wait_drained();
    rand_items = 0;

    // Hold the receiver off while the sender keeps offering, overflowing the store.
    hold_reqs++;
    add_byte("q");
    for (i = 0; i < 40; i++) add_byte(CH_LF);
    add_byte("z");
    close_string();
    for (i = 0; i < 6; i++) gen_form_string();
    wait_drained();

    next_pause = rand_items + 130;
    while (rand_items < RAND_ITEMS) begin
      gen_form_string();
      if (rand_items >= next_pause) begin
        wait_drained();
        next_pause = rand_items + 130;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (decoded_q.size() != 0)
      flag_mismatch($sformatf("%0d expected beats never arrived", decoded_q.size()));
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/ufd_pkg.sv
hdl/ufd_ctrl.sv
hdl/ufd_datapath.sv
hdl/url_form_decoder.sv
test/testbench.sv
